FILE: rtl/fwt_pkg.sv
// Package for the binary indexed tree range-sum block.
// Holds sizes, the memory request type and position helpers.
// No dependencies.
package fwt_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned POS_W   = IDX_W + 1;
  localparam int unsigned DATA_W  = 32;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ENTRIES);

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

  // Positions are 1-based; entry pos lives at address pos - 1.
  function automatic addr_t addr_of(input pos_t pos);
    pos_t p;
    p = pos - pos_t'(1);
    return p[ADDR_W-1:0];
  endfunction

  function automatic pos_t low_bit(input pos_t pos);
    return pos & (~pos + pos_t'(1));
  endfunction

endpackage

FILE: rtl/fwt_store.sv
// Tree storage: one write port and one read port with registered read data.
// Depends on fwt_pkg for sizes and the memory request type.
module fwt_store (
  input  logic              clk,
  input  fwt_pkg::mem_req_t req,
  output fwt_pkg::word_t    rd_data
);

  fwt_pkg::word_t mem [fwt_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: rtl/fwt_ctrl.sv
// Sequencer for the tree: clearing pass, update walk and two query walks.
// Depends on fwt_pkg; drives the storage through a mem_req_t request.
module fwt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       cmd,
  input  logic [fwt_pkg::IDX_W-1:0]  update_index,
  input  logic signed [31:0]         add_value,
  input  logic [fwt_pkg::IDX_W-1:0]  range_lo,
  input  logic [fwt_pkg::IDX_W-1:0]  range_hi,
  input  fwt_pkg::word_t             rd_data,
  output fwt_pkg::mem_req_t          req,
  output logic                       busy,
  output logic                       done,
  output logic signed [31:0]         range_sum,
  output logic                       index_error
);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_UPD_RD  = 7'b0000100,
    S_UPD_WR  = 7'b0001000,
    S_QRY_HI  = 7'b0010000,
    S_QRY_LO  = 7'b0100000,
    S_QRY_OUT = 7'b1000000
  } state_t;

  state_t                     state, state_next;
  fwt_pkg::pos_t              pos, pos_next;
  fwt_pkg::word_t             acc, acc_next, acc_cur;
  fwt_pkg::word_t             val, val_next;
  logic [fwt_pkg::IDX_W-1:0]  lo_m1, lo_m1_next;
  logic                       rd_pend, rd_pend_next;
  logic                       rd_neg, rd_neg_next;
  fwt_pkg::addr_t             clr_addr, clr_addr_next;
  logic                       done_next;
  logic signed [31:0]         range_sum_next;
  logic                       index_error_next;
  logic                       upd_bad, qry_bad;

  assign busy = (state != S_IDLE);

  assign upd_bad = (update_index == '0) || (update_index > fwt_pkg::LAST_POS);
  assign qry_bad = (range_lo == '0) || (range_lo > fwt_pkg::LAST_POS) ||
                   (range_hi > fwt_pkg::LAST_POS);

  always_comb begin
    acc_cur = acc;
    if (rd_pend) begin
      acc_cur = rd_neg ? (acc - rd_data) : (acc + rd_data);
    end

    state_next       = state;
    pos_next         = pos;
    acc_next         = acc_cur;
    val_next         = val;
    lo_m1_next       = lo_m1;
    rd_pend_next     = 1'b0;
    rd_neg_next      = rd_neg;
    clr_addr_next    = clr_addr;
    done_next        = 1'b0;
    range_sum_next   = range_sum;
    index_error_next = index_error;
    req              = '0;

    unique case (state)
      S_CLEAR: begin
        req.wr_en     = 1'b1;
        req.wr_addr   = clr_addr;
        req.wr_data   = '0;
        clr_addr_next = clr_addr + fwt_pkg::addr_t'(1);
        if (clr_addr == fwt_pkg::addr_t'(fwt_pkg::ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (!cmd) begin
            if (upd_bad) begin
              done_next        = 1'b1;
              range_sum_next   = '0;
              index_error_next = 1'b1;
            end else begin
              pos_next   = {1'b0, update_index};
              val_next   = add_value;
              state_next = S_UPD_RD;
            end
          end else begin
            if (qry_bad) begin
              done_next        = 1'b1;
              range_sum_next   = '0;
              index_error_next = 1'b1;
            end else begin
              pos_next   = {1'b0, range_hi};
              lo_m1_next = range_lo - fwt_pkg::IDX_W'(1);
              acc_next   = '0;
              state_next = S_QRY_HI;
            end
          end
        end
      end
      S_UPD_RD: begin
        if (pos > fwt_pkg::pos_t'(fwt_pkg::ENTRIES)) begin
          done_next        = 1'b1;
          range_sum_next   = '0;
          index_error_next = 1'b0;
          state_next       = S_IDLE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = fwt_pkg::addr_of(pos);
          state_next  = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = fwt_pkg::addr_of(pos);
        req.wr_data = rd_data + val;
        pos_next    = pos + fwt_pkg::low_bit(pos);
        state_next  = S_UPD_RD;
      end
      S_QRY_HI: begin
        if (pos == '0) begin
          pos_next   = {1'b0, lo_m1};
          state_next = S_QRY_LO;
        end else begin
          req.rd_en    = 1'b1;
          req.rd_addr  = fwt_pkg::addr_of(pos);
          rd_pend_next = 1'b1;
          rd_neg_next  = 1'b0;
          pos_next     = pos - fwt_pkg::low_bit(pos);
        end
      end
      S_QRY_LO: begin
        if (pos == '0) begin
          state_next = S_QRY_OUT;
        end else begin
          req.rd_en    = 1'b1;
          req.rd_addr  = fwt_pkg::addr_of(pos);
          rd_pend_next = 1'b1;
          rd_neg_next  = 1'b1;
          pos_next     = pos - fwt_pkg::low_bit(pos);
        end
      end
      S_QRY_OUT: begin
        done_next        = 1'b1;
        range_sum_next   = acc_cur;
        index_error_next = 1'b0;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      rd_pend  <= rd_pend_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    acc         <= acc_next;
    val         <= val_next;
    lo_m1       <= lo_m1_next;
    rd_neg      <= rd_neg_next;
    range_sum   <= range_sum_next;
    index_error <= index_error_next;
  end

endmodule

FILE: rtl/fenwick_tree_range_sum_top.sv
// Binary indexed tree range-sum block: updates walk up, queries walk down twice.
// An update reads and writes one entry per tree level touched on its way up;
// a query reads each entry on both prefix paths, the high one first, then the low one.
// One item is taken at a time; the next is taken as the result beat shows, also for a bad index.
// After reset a clearing pass zeroes all 1024 entries of the store while busy is high.
// Each result beat shows for one cycle on done; the receiver cannot stall.
module fenwick_tree_range_sum_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd,
  input  logic [fwt_pkg::IDX_W-1:0]  update_index,
  input  logic signed [31:0]         add_value,
  input  logic [fwt_pkg::IDX_W-1:0]  range_lo,
  input  logic [fwt_pkg::IDX_W-1:0]  range_hi,
  output logic                       done,
  output logic signed [31:0]         range_sum,
  output logic                       index_error
);

  fwt_pkg::mem_req_t req;
  fwt_pkg::word_t    rd_data;

  fwt_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  fwt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .update_index (update_index),
    .add_value    (add_value),
    .range_lo     (range_lo),
    .range_hi     (range_hi),
    .rd_data      (rd_data),
    .req          (req),
    .busy         (busy),
    .done         (done),
    .range_sum    (range_sum),
    .index_error  (index_error)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while the sequencer is still busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (range_sum == '0))
    else $error("error beat carries a nonzero sum");

  a_bad_upd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cmd &&
     ((update_index == '0) || (update_index > fwt_pkg::LAST_POS)))
    |=> (done && index_error && !busy))
    else $error("bad update index did not raise an error beat");

  a_clear_busy: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("block left reset without the clearing pass");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (req.wr_en && req.rd_en) |-> (req.wr_addr != req.rd_addr))
    else $error("read and write to the same entry in one cycle");

endmodule
